/* design/lmf_pkg.sv */
package lmf_pkg;

  localparam int RING_PIXELS_DEF  = 30;
  localparam int STRIP_PIXELS_DEF = 28;
  localparam int SPIN_COUNT_DEF   = 3;

  localparam int LEVEL_W  = 20;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 20;
  localparam int SCALE_W  = 14;
  localparam int AVG_W    = 24;
  localparam int ACC_W    = 28;
  localparam int IDX_W    = 5;
  localparam int LIT_W    = 6;
  localparam int RNG_W    = 16;
  localparam int CMD_DEPTH = 4;

  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = PERIOD_W'(10000);
  localparam logic [SCALE_W-1:0]  FULL_SCALE_RST    = SCALE_W'(150);
  localparam logic [RNG_W-1:0]    RNG_SEED          = 16'hACE1;
  localparam logic [RNG_W-1:0]    RNG_MASK          = 16'hB400;
  localparam logic [31:0]         RECIP_TEN         = 32'hCCCCCCCD;
  localparam int                  RECIP_SHIFT       = 35;
  localparam logic [23:0]         COLOR_ARMED       = {8'd3, 8'd244, 8'd252};
  localparam logic [23:0]         COLOR_SAFE        = {8'd255, 8'd0, 8'd0};

  typedef enum logic [0:0] {
    REG_UPDATE_PERIOD = 1'b0,
    REG_FULL_SCALE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  time_us;
    logic               blank;
    logic               armed;
    logic               motor_running;
  } item_t;

  typedef struct packed {
    logic             which_string;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic             blank;
    logic             motor;
    logic             armed;
    logic [LIT_W-1:0] lit;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ACC,
    F_AVG,
    F_LOAD,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RING,
    B_STRIP
  } back_state_t;

  function automatic logic [RNG_W-1:0] lfsr_step(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ RNG_MASK;
    end
    return n;
  endfunction

  function automatic logic [7:0] rng_comp(input logic [RNG_W-1:0] s);
    return (s[7:0] == 8'hFF) ? 8'd0 : s[7:0];
  endfunction

endpackage

/* design/led_level_meter_frame_unit.sv */
// Level meter frame generator for a ring and a strip of LEDs.
// Input side is a queue: an item (level sample, time, mode flags) is taken
// when push is high and full is low. Each item updates the running average
// and, when the update period has elapsed, produces one frame of ring pixels
// followed by strip pixels. Results are read as a queue: while empty is low
// the oldest pixel is on result, and pop takes it; frame_end marks the last.
// Configuration writes use cfg_valid and cfg_ready; cfg_ready is always high.
// An item without a frame occupies the input through the accumulate and
// average steps. An item with a frame also occupies it through the load
// step, the bit-serial divider that scales the average to a lit count, and
// the push of the command. Frames go through a four-entry command queue to
// the pixel engine, which emits one pixel per cycle while the receiver pops.
// When the receiver stalls, the pixel engine holds its output, the command
// queue fills and full then stays high until frames drain.
// Reset restores the default registers, clears the average and last frame
// time, seeds the random generator and places the spinner at its start.
module led_level_meter_frame_unit
  import lmf_pkg::*;
#(
  parameter int RING_PIXELS  = RING_PIXELS_DEF,
  parameter int STRIP_PIXELS = STRIP_PIXELS_DEF,
  parameter int SPIN_COUNT   = SPIN_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  output logic                empty,
  input  logic                pop,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_reg_t            cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  assign cfg_ready = 1'b1;

  lmf_front #(
    .STRIP_PIXELS(STRIP_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  lmf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_cmd    (fr_cmd),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_cmd   (bk_cmd)
  );

  lmf_back #(
    .RING_PIXELS  (RING_PIXELS),
    .STRIP_PIXELS (STRIP_PIXELS),
    .SPIN_COUNT   (SPIN_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* design/lmf_cmd_fifo.sv */
module lmf_cmd_fifo
  import lmf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic do_wr;
  logic do_rd;

  assign in_ready  = (count != (PTR_W+1)'(CMD_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = mem[rd_ptr];
  assign do_wr     = in_valid & in_ready;
  assign do_rd     = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/lmf_front.sv */
module lmf_front
  import lmf_pkg::*;
#(
  parameter int STRIP_PIXELS = STRIP_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  item_t               item,
  input  logic                cfg_we,
  input  cfg_reg_t            cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);

  localparam int NUM_W = SCALE_W + $clog2(STRIP_PIXELS);
  localparam int CNT_W = $clog2(NUM_W);

  front_state_t fstate;
  front_state_t fstate_next;

  logic [PERIOD_W-1:0] update_period;
  logic [SCALE_W-1:0]  full_scale;
  logic [LEVEL_W-1:0]  level;
  logic [TIME_W-1:0]   now;
  logic                blank;
  logic                armed;
  logic                motor;
  logic [ACC_W-1:0]    acc;
  logic [AVG_W-1:0]    avg_level;
  logic [TIME_W-1:0]   last_frame_time;
  logic                go;
  logic [NUM_W-1:0]    num;
  logic [SCALE_W-1:0]  rem;
  logic [CNT_W-1:0]    cnt;

  logic                accept;
  logic [59:0]         prod;
  logic [SCALE_W-1:0]  divisor;
  logic [SCALE_W:0]    rem_sh;
  logic [SCALE_W:0]    rem_diff;
  logic                q_bit;
  logic [TIME_W-1:0]   elapsed;

  assign accept   = push & ~full;
  assign prod     = 60'(acc) * 60'(RECIP_TEN);
  assign divisor  = (full_scale == '0) ? SCALE_W'(1) : full_scale;
  assign rem_sh   = {rem, num[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign elapsed  = now - last_frame_time;

  always_comb begin
    cmd.blank = blank;
    cmd.motor = motor;
    cmd.armed = armed;
    cmd.lit   = (num > NUM_W'(STRIP_PIXELS)) ? LIT_W'(STRIP_PIXELS) : num[LIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_comb begin
    fstate_next = fstate;
    full        = 1'b1;
    cmd_valid   = 1'b0;
    unique case (fstate)
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          fstate_next = F_ACC;
        end
      end
      F_ACC: begin
        fstate_next = F_AVG;
      end
      F_AVG: begin
        fstate_next = go ? F_LOAD : F_IDLE;
      end
      F_LOAD: begin
        fstate_next = F_DIV;
      end
      F_DIV: begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          fstate_next = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          fstate_next = F_IDLE;
        end
      end
      default: begin
        fstate_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      update_period   <= UPDATE_PERIOD_RST;
      full_scale      <= FULL_SCALE_RST;
      avg_level       <= '0;
      last_frame_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_UPDATE_PERIOD: update_period <= cfg_data;
          REG_FULL_SCALE:    full_scale    <= cfg_data[SCALE_W-1:0];
        endcase
      end
      if (fstate == F_AVG) begin
        avg_level <= prod[RECIP_SHIFT +: AVG_W];
        if (go) begin
          last_frame_time <= now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level <= item.level;
      now   <= item.time_us;
      blank <= item.blank;
      armed <= item.armed;
      motor <= item.motor_running;
    end
    if (fstate == F_ACC) begin
      acc <= (ACC_W'(avg_level) << 3) + ACC_W'(avg_level) + (ACC_W'(level) << 4);
      go  <= (elapsed >= TIME_W'(update_period));
    end
    if (fstate == F_LOAD) begin
      num <= NUM_W'(avg_level[AVG_W-1:10]) * NUM_W'(STRIP_PIXELS);
      rem <= '0;
      cnt <= '0;
    end
    if (fstate == F_DIV) begin
      rem <= q_bit ? rem_diff[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
      num <= {num[NUM_W-2:0], q_bit};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* design/lmf_back.sv */
module lmf_back
  import lmf_pkg::*;
#(
  parameter int RING_PIXELS  = RING_PIXELS_DEF,
  parameter int STRIP_PIXELS = STRIP_PIXELS_DEF,
  parameter int SPIN_COUNT   = SPIN_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int LOG_W = $clog2(STRIP_PIXELS);

  back_state_t bstate;
  back_state_t bstate_next;

  cmd_t             cur;
  logic [IDX_W-1:0] pix;
  logic [IDX_W-1:0] spin_pos [SPIN_COUNT];
  logic [RNG_W-1:0] rng_reg;
  result_t          res;
  logic             res_valid;

  logic [23:0]      rain_tab [STRIP_PIXELS];
  logic             advance;
  logic             ring_last;
  logic             strip_last;
  logic             spin_on;
  logic [RNG_W-1:0] rng1;
  logic [RNG_W-1:0] rng2;
  logic [RNG_W-1:0] rng3;
  logic [LOG_W-1:0] logical;
  logic [23:0]      ring_rgb;
  logic [23:0]      strip_rgb;

  for (genvar j = 0; j < STRIP_PIXELS; j++) begin : g_rain
    localparam int S = (6 * j) / STRIP_PIXELS;
    localparam int Q = (6 * j) % STRIP_PIXELS;
    localparam int X = (S % 2 == 1) ? (255 * (STRIP_PIXELS - Q)) / STRIP_PIXELS
                                    : (255 * Q) / STRIP_PIXELS;
    localparam int R = (S == 0 || S == 5) ? 255 : ((S == 1 || S == 4) ? X : 0);
    localparam int G = (S == 1 || S == 2) ? 255 : ((S == 0 || S == 3) ? X : 0);
    localparam int B = (S == 3 || S == 4) ? 255 : ((S == 2 || S == 5) ? X : 0);
    assign rain_tab[j] = {8'(R), 8'(G), 8'(B)};
  end

  assign advance    = ~res_valid | pop;
  assign empty      = ~res_valid;
  assign result     = res;
  assign ring_last  = (pix == IDX_W'(RING_PIXELS - 1));
  assign strip_last = (pix == IDX_W'(STRIP_PIXELS - 1));
  assign rng1       = lfsr_step(rng_reg);
  assign rng2       = lfsr_step(rng1);
  assign rng3       = lfsr_step(rng2);
  assign logical    = LOG_W'(STRIP_PIXELS - 1) - pix[LOG_W-1:0];

  always_comb begin
    spin_on = 1'b0;
    for (int k = 0; k < SPIN_COUNT; k++) begin
      if (spin_pos[k] == pix) begin
        spin_on = 1'b1;
      end
    end
  end

  always_comb begin
    if (cur.blank) begin
      ring_rgb = '0;
    end else if (cur.motor) begin
      ring_rgb = {rng_comp(rng1), rng_comp(rng2), rng_comp(rng3)};
    end else if (spin_on) begin
      ring_rgb = cur.armed ? COLOR_ARMED : COLOR_SAFE;
    end else begin
      ring_rgb = '0;
    end
    if (!cur.blank && (LIT_W'(logical) < cur.lit)) begin
      strip_rgb = rain_tab[logical];
    end else begin
      strip_rgb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  always_comb begin
    bstate_next = bstate;
    cmd_ready   = 1'b0;
    unique case (bstate)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          bstate_next = B_RING;
        end
      end
      B_RING: begin
        if (advance && ring_last) begin
          bstate_next = B_STRIP;
        end
      end
      B_STRIP: begin
        if (advance && strip_last) begin
          bstate_next = B_IDLE;
        end
      end
      default: begin
        bstate_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      rng_reg   <= RNG_SEED;
      for (int k = 0; k < SPIN_COUNT; k++) begin
        spin_pos[k] <= IDX_W'(k);
      end
    end else begin
      if (advance && (bstate == B_RING || bstate == B_STRIP)) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (advance && bstate == B_RING && !cur.blank) begin
        if (cur.motor) begin
          rng_reg <= rng3;
        end else if (ring_last) begin
          for (int k = 0; k < SPIN_COUNT; k++) begin
            spin_pos[k] <= (spin_pos[k] == IDX_W'(RING_PIXELS - 1)) ? '0
                                                                   : spin_pos[k] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bstate == B_IDLE && cmd_valid) begin
      cur <= cmd;
      pix <= '0;
    end
    if (advance && bstate == B_RING) begin
      res.which_string <= 1'b0;
      res.pixel_index  <= pix;
      {res.red, res.green, res.blue} <= ring_rgb;
      res.frame_end    <= 1'b0;
      pix <= ring_last ? '0 : pix + 1'b1;
    end
    if (advance && bstate == B_STRIP) begin
      res.which_string <= 1'b1;
      res.pixel_index  <= pix;
      {res.red, res.green, res.blue} <= strip_rgb;
      res.frame_end    <= strip_last;
      pix <= pix + 1'b1;
    end
  end

endmodule
